// ----- rtl/rc4_pkg.sv -----
// Shared types, constants and helpers for the RC4 keystream engine.
// Used by rc4_core, rc4_keystream_cipher and the testbench; depends on nothing else.
package rc4_pkg;

    localparam int KEY_BYTES_MAX = 32;
    localparam int KEY_WORDS     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_IDX_W     = $clog2(KEY_BYTES_MAX);
    localparam int SBOX_DEPTH    = 256;
    localparam int SBOX_AW       = $clog2(SBOX_DEPTH);
    localparam int BYTE_W        = 8;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = CFG_IDX_W'(4);

    // Opcodes and result kinds.
    localparam logic OP_SCHEDULE   = 1'b0;
    localparam logic OP_CRYPT      = 1'b1;
    localparam logic KIND_SCHEDULE = 1'b0;
    localparam logic KIND_CRYPT    = 1'b1;

    typedef struct packed {
        logic [KEY_BYTES_MAX-1:0][BYTE_W-1:0] key;
        logic [KEY_LEN_W-1:0]                 len_eff;
    } t_key_cfg;

    typedef struct packed {
        logic              start;
        logic              opcode;
        logic [BYTE_W-1:0] data;
    } t_core_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] out_byte;
        logic              kind;
    } t_core_sts;

    // A zero length acts as one byte; lengths above the maximum saturate.
    function automatic logic [KEY_LEN_W-1:0] eff_key_len(input logic [KEY_LEN_W-1:0] len);
        logic [KEY_LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = KEY_LEN_W'(1);
        end else if (len > KEY_LEN_W'(KEY_BYTES_MAX)) begin
            res = KEY_LEN_W'(KEY_BYTES_MAX);
        end
        return res;
    endfunction

endpackage

// ----- rtl/rc4_ram.sv -----
// Generic single-port RAM with registered read data.
// Stand-alone; holds the permutation store of the RC4 engine.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rc4_core.sv -----
// Sequencer and datapath of the RC4 engine around one single-port permutation RAM.
// Depends on rc4_pkg and rc4_ram.
module rc4_core
    import rc4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_req i_ctl,
    input  t_key_cfg  i_key,
    input  logic      i_out_free,
    output t_core_sts o_sts
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_INIT   = 12'b0000_0000_0010,
        S_KS_RDI = 12'b0000_0000_0100,
        S_KS_RDJ = 12'b0000_0000_1000,
        S_KS_WRI = 12'b0000_0001_0000,
        S_KS_WRJ = 12'b0000_0010_0000,
        S_CR_RDX = 12'b0000_0100_0000,
        S_CR_RDY = 12'b0000_1000_0000,
        S_CR_WRX = 12'b0001_0000_0000,
        S_CR_WRY = 12'b0010_0000_0000,
        S_CR_RDS = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // r_yb is the second index before the entry at r_x is added in; the add
    // happens when the next crypt beat reads that entry anyway.
    logic [SBOX_AW-1:0]   r_x, n_x;
    logic [SBOX_AW-1:0]   r_yb, n_yb;
    logic [SBOX_AW-1:0]   r_y, n_y;
    logic [SBOX_AW-1:0]   r_i, n_i;
    logic [SBOX_AW-1:0]   r_j, n_j;
    logic [KEY_IDX_W-1:0] r_k, n_k;
    logic [BYTE_W-1:0]    r_sx, n_sx;
    logic [BYTE_W-1:0]    r_sy, n_sy;
    logic [BYTE_W-1:0]    r_data, n_data;
    logic                 r_kind, n_kind;

    logic                 ram_we;
    logic                 ram_re;
    logic [SBOX_AW-1:0]   ram_addr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic [BYTE_W-1:0]    ram_rdata;

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(SBOX_DEPTH)
    ) u_sbox (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_yb      = r_yb;
        n_y       = r_y;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_data    = r_data;
        n_kind    = r_kind;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_i;
        ram_wdata = r_i;

        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_data = i_ctl.data;
                    if (i_ctl.opcode == OP_SCHEDULE) begin
                        n_kind  = KIND_SCHEDULE;
                        n_i     = '0;
                        n_state = S_INIT;
                    end else begin
                        n_kind  = KIND_CRYPT;
                        n_state = S_CR_RDX;
                    end
                end
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_addr  = r_i;
                ram_wdata = r_i;
                n_i       = r_i + SBOX_AW'(1);
                if (r_i == SBOX_AW'(SBOX_DEPTH - 1)) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = S_KS_RDI;
                end
            end
            S_KS_RDI: begin
                ram_re   = 1'b1;
                ram_addr = r_i;
                n_state  = S_KS_RDJ;
            end
            S_KS_RDJ: begin
                n_sx     = ram_rdata;
                n_j      = r_j + ram_rdata + i_key.key[r_k];
                ram_re   = 1'b1;
                ram_addr = n_j;
                n_state  = S_KS_WRI;
            end
            S_KS_WRI: begin
                ram_we    = 1'b1;
                ram_addr  = r_i;
                ram_wdata = ram_rdata;
                n_state   = S_KS_WRJ;
            end
            S_KS_WRJ: begin
                ram_we    = 1'b1;
                ram_addr  = r_j;
                ram_wdata = r_sx;
                n_i       = r_i + SBOX_AW'(1);
                if (KEY_LEN_W'(r_k) + KEY_LEN_W'(1) == i_key.len_eff) begin
                    n_k = '0;
                end else begin
                    n_k = r_k + KEY_IDX_W'(1);
                end
                if (r_i == SBOX_AW'(SBOX_DEPTH - 1)) begin
                    n_x     = SBOX_AW'(1);
                    n_yb    = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_KS_RDI;
                end
            end
            S_CR_RDX: begin
                ram_re   = 1'b1;
                ram_addr = r_x;
                n_state  = S_CR_RDY;
            end
            S_CR_RDY: begin
                n_sx     = ram_rdata;
                n_y      = r_yb + ram_rdata;
                ram_re   = 1'b1;
                ram_addr = n_y;
                n_state  = S_CR_WRX;
            end
            S_CR_WRX: begin
                n_sy      = ram_rdata;
                ram_we    = 1'b1;
                ram_addr  = r_x;
                ram_wdata = ram_rdata;
                n_state   = S_CR_WRY;
            end
            S_CR_WRY: begin
                ram_we    = 1'b1;
                ram_addr  = r_y;
                ram_wdata = r_sx;
                n_state   = S_CR_RDS;
            end
            S_CR_RDS: begin
                ram_re   = 1'b1;
                ram_addr = r_sx + r_sy;
                n_x      = r_x + SBOX_AW'(1);
                n_yb     = r_y;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_yb    <= '0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_yb    <= n_yb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y    <= n_y;
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_data <= n_data;
        r_kind <= n_kind;
    end

    always_comb begin
        o_sts.busy     = (r_state != S_IDLE);
        o_sts.done     = (r_state == S_DONE);
        o_sts.kind     = r_kind;
        o_sts.out_byte = (r_kind == KIND_CRYPT) ? (r_data ^ ram_rdata) : '0;
    end

endmodule

// ----- rtl/rc4_keystream_cipher.sv -----
// RC4 keystream engine, top level. A crypt beat swaps S[x] and S[y] and reads
// S[S[x]+S[y]]; a key schedule beat makes 256 identity writes, then swaps S[i] and
// S[j] in each of 256 steps, all on the one single-port RAM port. One beat is worked
// at a time; the next is taken the cycle after the result is registered. Synchronous
// active-low reset clears the crypt indices x and yb, the key registers (length 16)
// and control; the permutation RAM is not cleared and is undefined until scheduled.
module rc4_keystream_cipher
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [BYTE_W-1:0]     i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_result_kind,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [KEY_WORDS-1:0][CFG_DATA_W-1:0] r_key_word;
    logic [KEY_LEN_W-1:0]                 r_key_length;
    logic                                 r_out_valid;
    logic [BYTE_W-1:0]                    r_out_byte;
    logic                                 r_result_kind;

    t_core_req core_req;
    t_core_sts core_sts;
    t_key_cfg  key_cfg;
    logic      out_free;
    logic      in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word   <= '0;
            r_key_length <= KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_WORD_0: r_key_word[0] <= i_cfg_data;
                CFG_KEY_WORD_1: r_key_word[1] <= i_cfg_data;
                CFG_KEY_WORD_2: r_key_word[2] <= i_cfg_data;
                CFG_KEY_WORD_3: r_key_word[3] <= i_cfg_data;
                CFG_KEY_LENGTH: r_key_length  <= i_cfg_data[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Word 0 sits in the low bits, so key byte n is element n of the flat array.
    assign key_cfg.key     = r_key_word;
    assign key_cfg.len_eff = eff_key_len(r_key_length);

    assign in_accept       = i_in_valid && !core_sts.busy;
    assign core_req.start  = in_accept;
    assign core_req.opcode = i_opcode;
    assign core_req.data   = i_data_byte;
    assign out_free        = !r_out_valid || !i_out_stall;

    rc4_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (core_req),
        .i_key     (key_cfg),
        .i_out_free(out_free),
        .o_sts     (core_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_sts.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_sts.done && out_free) begin
            r_out_byte    <= core_sts.out_byte;
            r_result_kind <= core_sts.kind;
        end
    end

    assign o_in_stall    = core_sts.busy;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_result_kind = r_result_kind;

    // An accepted beat keeps the input side stalled while it is worked.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // A finished item that finds the output free is shown in the next cycle.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_sts.done && out_free) |=> o_out_valid)
        else $error("finished item not registered at the output");

    // Schedule results carry a zero byte.
    a_schedule_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == KIND_SCHEDULE)) |-> (o_out_byte == '0))
        else $error("schedule result with a nonzero byte");

endmodule

// ----- dv/rc4_keystream_cipher_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rc4_keystream_cipher: an RC4 predictor follows every
// accepted input beat and each result beat is compared with its expectation.
// Depends on rc4_pkg and the rc4_keystream_cipher RTL.
module rc4_keystream_cipher_test
    import rc4_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_BEATS   = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              kind;
    } t_cipher_result;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  opcode = OP_SCHEDULE;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  result_kind;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KEY_WORD_0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the permutation, the indices and the key registers.
    logic [BYTE_W-1:0]     perm [SBOX_DEPTH];
    logic [BYTE_W-1:0]     idx_x = '0;
    logic [BYTE_W-1:0]     idx_y = '0;
    logic [CFG_DATA_W-1:0] key_words [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  key_len = KEY_LEN_RESET;

    t_cipher_result pending_results [$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    rc4_keystream_cipher DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_data_byte   (data_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_result_kind (result_kind),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [BYTE_W-1:0] key_byte_at(int n);
        logic [CFG_DATA_W-1:0] w;
        w = key_words[n / 8];
        return w[(n % 8) * 8 +: 8];
    endfunction

    // Identity load followed by the 256-step key schedule.
    function automatic void schedule_key();
        int                len;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] t;
        if (key_len == '0) begin
            len = 1;
        end else if (int'(key_len) > KEY_BYTES_MAX) begin
            len = KEY_BYTES_MAX;
        end else begin
            len = int'(key_len);
        end
        for (int i = 0; i < SBOX_DEPTH; i++) begin
            perm[i] = BYTE_W'(i);
        end
        acc = '0;
        for (int i = 0; i < SBOX_DEPTH; i++) begin
            acc = acc + perm[i] + key_byte_at(i % len);
            t = perm[i];
            perm[i] = perm[acc];
            perm[acc] = t;
        end
        idx_x = BYTE_W'(1);
        idx_y = perm[1];
    endfunction

    function automatic logic [BYTE_W-1:0] crypt_byte(logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] t;
        sum = perm[idx_x] + perm[idx_y];
        t = perm[idx_x];
        perm[idx_x] = perm[idx_y];
        perm[idx_y] = t;
        idx_x = idx_x + BYTE_W'(1);
        idx_y = idx_y + perm[idx_x];
        return d ^ perm[sum];
    endfunction

    function automatic t_cipher_result predict_rc4(logic op, logic [BYTE_W-1:0] d);
        t_cipher_result r;
        if (op == OP_SCHEDULE) begin
            schedule_key();
            r.out_byte = '0;
            r.kind = KIND_SCHEDULE;
        end else begin
            r.out_byte = crypt_byte(d);
            r.kind = KIND_CRYPT;
        end
        return r;
    endfunction

    function automatic logic [KEY_WORDS*CFG_DATA_W-1:0] random_key();
        logic [KEY_WORDS*CFG_DATA_W-1:0] k;
        for (int i = 0; i < KEY_WORDS * 2; i++) begin
            k[i * 32 +: 32] = $urandom();
        end
        return k;
    endfunction

    // Valid is left high after acceptance; a drain, or an idle wait at the start of the next call, lowers it.
    task automatic send_beat(input logic op, input logic [BYTE_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= d;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        pending_results.push_back(predict_rc4(op, d));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_key(input logic [KEY_WORDS*CFG_DATA_W-1:0] key,
                               input logic [KEY_LEN_W-1:0] len, input bit with_len);
        write_reg(CFG_KEY_WORD_0, key[0 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(CFG_KEY_WORD_1, key[1 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(CFG_KEY_WORD_2, key[2 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(CFG_KEY_WORD_3, key[3 * CFG_DATA_W +: CFG_DATA_W]);
        for (int i = 0; i < KEY_WORDS; i++) begin
            key_words[i] = key[i * CFG_DATA_W +: CFG_DATA_W];
        end
        if (with_len) begin
            write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
            key_len = len;
        end
        cfg_we <= 1'b0;
    endtask

    // The key length register is left at its reset value here.
    task automatic test_reset_key_length();
        program_key(random_key(), KEY_LEN_RESET, 1'b0);
        send_beat(OP_SCHEDULE, 8'h00);
        send_beat(OP_CRYPT, 8'h00);
        send_beat(OP_CRYPT, 8'hFF);
        send_beat(OP_CRYPT, 8'h5A);
        send_beat(OP_CRYPT, 8'hA5);
        wait_drained();
    endtask

    task automatic test_key_length_extremes();
        program_key('1, KEY_LEN_W'(1), 1'b1);
        send_beat(OP_SCHEDULE, 8'hFF);
        send_beat(OP_CRYPT, 8'h00);
        send_beat(OP_CRYPT, 8'hFF);
        wait_drained();

        // A second schedule right after the first must start again from identity.
        program_key(random_key(), KEY_LEN_W'(KEY_BYTES_MAX), 1'b1);
        send_beat(OP_SCHEDULE, 8'h00);
        send_beat(OP_SCHEDULE, 8'h00);
        send_beat(OP_CRYPT, 8'h00);
        send_beat(OP_CRYPT, 8'hFF);
        wait_drained();

        // A zero length acts as a one-byte key.
        program_key(random_key(), KEY_LEN_W'(0), 1'b1);
        send_beat(OP_SCHEDULE, 8'h00);
        send_beat(OP_CRYPT, 8'h00);
        send_beat(OP_CRYPT, 8'h80);
        wait_drained();

        // Lengths past the maximum saturate.
        program_key(random_key(), KEY_LEN_W'(KEY_BYTES_MAX + 1), 1'b1);
        send_beat(OP_SCHEDULE, 8'h00);
        send_beat(OP_CRYPT, 8'h00);
        send_beat(OP_CRYPT, 8'h01);
        wait_drained();

        program_key('0, '1, 1'b1);
        send_beat(OP_SCHEDULE, 8'h00);
        send_beat(OP_CRYPT, 8'h00);
        send_beat(OP_CRYPT, 8'hFF);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int                   idle_pct [4]  = '{0, 82, 0, 35};
        int                   stall_pct [4] = '{0, 0, 82, 35};
        logic [KEY_LEN_W-1:0] len;
        logic [BYTE_W-1:0]    d;
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            send_idle_pct  = idle_pct[seg / 2];
            recv_stall_pct = stall_pct[seg / 2];
            if ($urandom_range(5) == 0) begin
                len = KEY_LEN_W'($urandom_range(63));
            end else begin
                len = KEY_LEN_W'($urandom_range(KEY_BYTES_MAX, 1));
            end
            program_key(random_key(), len, 1'b1);
            send_beat(OP_SCHEDULE, BYTE_W'($urandom_range(255)));
            for (int n = 1; n < SEGMENT_BEATS; n++) begin
                d = ($urandom_range(7) == 0) ? '0 : BYTE_W'($urandom_range(255));
                if ($urandom_range(49) == 0) begin
                    send_beat(OP_SCHEDULE, d);
                end else begin
                    send_beat(OP_CRYPT, d);
                end
                // Now and then the sender holds off until the pipeline is empty.
                if ($urandom_range(39) == 0) begin
                    wait_drained();
                end
            end
            wait_drained();
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin : check_results
        t_cipher_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: out_byte %0h, result_kind %0b",
                       out_byte, result_kind);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
                    mismatches++;
                end
                if (result_kind !== want.kind) begin
                    $error("result_kind: expected %0b, actual %0b", want.kind, result_kind);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        foreach (key_words[i]) begin
            key_words[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key_length();
        test_key_length_extremes();
        test_random_traffic();
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
